// ===== rtl/core/pps_pkg.sv =====
// Shared constants, codes and slot record type for the priority scheduler.
`default_nettype none

package pps_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int TIME_BITS_DEF = 16;

  localparam int OP_W   = 1;
  localparam int SLOT_W = 3;
  localparam int VAL_W  = 16;
  localparam int PRIO_W = 8;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

  localparam logic [VAL_W-1:0] WAIT_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0]  arrive;
    logic [VAL_W-1:0]  burst;
    logic [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]  rem;
    logic [VAL_W-1:0]  waitc;
  } slot_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/pps_if.sv =====
// Request and result channel interfaces of the priority scheduler.
`default_nettype none

interface pps_req_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::OP_W-1:0]    op;
  logic [pps_pkg::SLOT_W-1:0]  slot;
  logic [pps_pkg::VAL_W-1:0]   arrival;
  logic [pps_pkg::VAL_W-1:0]   burst;
  logic [pps_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, op, slot, arrival, burst, priority_req, input ready);
  modport sink   (input valid, op, slot, arrival, burst, priority_req, output ready);
endinterface

interface pps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::KIND_W-1:0]  kind;
  logic [pps_pkg::SLOT_W-1:0]  run_slot;
  logic [pps_pkg::VAL_W-1:0]   turnaround;
  logic [pps_pkg::VAL_W-1:0]   waited;
  logic [pps_pkg::VAL_W-1:0]   now;

  modport source (output valid, kind, run_slot, turnaround, waited, now, input ready);
  modport sink   (input valid, kind, run_slot, turnaround, waited, now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pps_slot_table.sv =====
// Task slot table: one write port, one read port with registered read data.
`default_nettype none

module pps_slot_table #(
  parameter  int SLOTS = pps_pkg::SLOTS_DEF,
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [IW-1:0]       wr_addr,
  input  wire pps_pkg::slot_word_t wr_data,
  input  wire logic                rd_en,
  input  wire logic [IW-1:0]       rd_addr,
  output      pps_pkg::slot_word_t rd_data
);

  pps_pkg::slot_word_t mem_r [SLOTS];
  pps_pkg::slot_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Top level: preemptive priority scheduler with a slot-serial scan sequencer.
// Load request: result registered on acceptance.
// Tick request: N = min(active_slots, SLOTS) slots are scanned, one slot read
//   per cycle through the single slot-table port, then one read-modify-write of the winner.
// One request in flight; the next is taken once the result register is free.
// Reset (synchronous, rst_n low): all slots empty, time zero, active_slots 8.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int SLOTS     = pps_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [pps_pkg::CFG_W-1:0] cfg_wr_data,
  pps_req_if.sink                        in_req,
  pps_rsp_if.source                      out_rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  // count width: wide enough for both the slot count and the 4-bit register
  localparam int NW = (CW > pps_pkg::CFG_W) ? CW : pps_pkg::CFG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FRD, ST_FWR} st_t;

  // Sequencer and scheduling state
  st_t                          st_r, st_nxt;
  logic [NW-1:0]                rd_cnt_r, rd_cnt_nxt;    // next slot to read
  logic                         pv_r, pv_nxt;            // read data in flight
  logic [IW-1:0]                p_idx_r, p_idx_nxt;      // slot of the in-flight read
  logic                         best_vld_r, best_vld_nxt;
  logic [IW-1:0]                best_idx_r, best_idx_nxt;
  logic [pps_pkg::PRIO_W-1:0]   best_prio_r, best_prio_nxt;
  logic                         best_inc_r, best_inc_nxt; // winner got a wait unit in scan
  logic [TIME_BITS-1:0]         time_r, time_nxt;
  logic [SLOTS-1:0]             occ_r, occ_nxt;          // slot holds a task (prio != 0)
  logic [SLOTS-1:0]             rdy_r, rdy_nxt;          // remaining count nonzero
  logic [pps_pkg::CFG_W-1:0]    cfg_r, cfg_nxt;

  // Result register
  logic                         out_vld_r, out_vld_nxt;
  logic [pps_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [pps_pkg::SLOT_W-1:0]   run_r, run_nxt;
  logic [pps_pkg::VAL_W-1:0]    tat_r, tat_nxt;
  logic [pps_pkg::VAL_W-1:0]    wtd_r, wtd_nxt;
  logic [pps_pkg::VAL_W-1:0]    now_r, now_nxt;

  // Slot table port
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  pps_pkg::slot_word_t          wr_data;
  logic                         rd_en;
  logic [IW-1:0]                rd_addr;
  pps_pkg::slot_word_t          rd_data;

  // Helpers
  logic                         out_free;
  logic                         in_acc;
  logic [NW-1:0]                act_ext;
  logic [NW-1:0]                n_act;
  logic                         slot_ok;
  logic [IW-1:0]                ld_addr;

  logic                         scan_hit;
  logic                         scan_rdy;
  logic                         scan_inc;
  logic                         scan_take;
  pps_pkg::slot_word_t          scan_word;

  logic [TIME_BITS-1:0]         time_inc;
  logic [TIME_BITS-1:0]         tat_full;
  logic [pps_pkg::VAL_W-1:0]    fin_rem;
  logic [pps_pkg::VAL_W-1:0]    fin_wait;
  pps_pkg::slot_word_t          fin_word;

  pps_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free     = !out_vld_r || out_rsp.ready;
  assign in_req.ready = (st_r == ST_IDLE) && out_free;
  assign in_acc       = in_req.valid && in_req.ready;

  // Participating slots: register value clamped to the table size
  assign act_ext = NW'(cfg_r);
  assign n_act   = (act_ext > NW'(SLOTS)) ? NW'(SLOTS) : act_ext;

  // Loads to a slot beyond the table are acknowledged but dropped
  assign slot_ok = ({{(32 - pps_pkg::SLOT_W){1'b0}}, in_req.slot} < 32'(SLOTS));
  assign ld_addr = IW'(in_req.slot);

  // Scan step on the slot whose data just came back from the table:
  // arrival refills remaining from burst, then every ready slot is charged one
  // waiting unit up front (undone later for the winner) and competes on priority.
  always_comb begin
    scan_hit  = occ_r[p_idx_r] && (TIME_BITS'(rd_data.arrive) == time_r);
    scan_rdy  = occ_r[p_idx_r] && (scan_hit ? (rd_data.burst != '0) : rdy_r[p_idx_r]);
    scan_inc  = scan_rdy && (rd_data.waitc != pps_pkg::WAIT_MAX);
    scan_take = scan_rdy && (!best_vld_r || (rd_data.prio < best_prio_r));
    scan_word        = rd_data;
    scan_word.rem    = scan_hit ? rd_data.burst : rd_data.rem;
    scan_word.waitc  = rd_data.waitc + pps_pkg::VAL_W'(scan_inc);
  end

  // Finish step on the winner: run one unit, take back its waiting unit
  always_comb begin
    time_inc       = time_r + TIME_BITS'(1);
    tat_full       = time_inc - TIME_BITS'(rd_data.arrive);
    fin_rem        = rd_data.rem - pps_pkg::VAL_W'(1);
    fin_wait       = best_inc_r ? (rd_data.waitc - pps_pkg::VAL_W'(1)) : rd_data.waitc;
    fin_word       = rd_data;
    fin_word.rem   = fin_rem;
    fin_word.waitc = fin_wait;
  end

  always_comb begin
    st_nxt        = st_r;
    rd_cnt_nxt    = rd_cnt_r;
    pv_nxt        = 1'b0;
    p_idx_nxt     = p_idx_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_inc_nxt  = best_inc_r;
    time_nxt      = time_r;
    occ_nxt       = occ_r;
    rdy_nxt       = rdy_r;
    cfg_nxt       = cfg_wr_en ? cfg_wr_data : cfg_r;

    out_vld_nxt   = out_vld_r && !out_rsp.ready;
    kind_nxt      = kind_r;
    run_nxt       = run_r;
    tat_nxt       = tat_r;
    wtd_nxt       = wtd_r;
    now_nxt       = now_r;

    wr_en         = 1'b0;
    wr_addr       = p_idx_r;
    wr_data       = scan_word;
    rd_en         = 1'b0;
    rd_addr       = rd_cnt_r[IW-1:0];

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.op == pps_pkg::OP_LOAD) begin
            // write the slot and acknowledge at once
            if (slot_ok) begin
              wr_en          = 1'b1;
              wr_addr        = ld_addr;
              wr_data.arrive = in_req.arrival;
              wr_data.burst  = in_req.burst;
              wr_data.prio   = in_req.priority_req;
              wr_data.rem    = '0;
              wr_data.waitc  = '0;
              occ_nxt[ld_addr] = (in_req.priority_req != '0);
              rdy_nxt[ld_addr] = 1'b0;
            end
            out_vld_nxt = 1'b1;
            kind_nxt    = pps_pkg::KIND_LOAD;
            run_nxt     = '0;
            tat_nxt     = '0;
            wtd_nxt     = '0;
            now_nxt     = pps_pkg::VAL_W'(time_r);
          end else begin
            st_nxt       = ST_SCAN;
            rd_cnt_nxt   = '0;
            best_vld_nxt = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // retire the slot read last cycle
        if (pv_r) begin
          wr_en            = 1'b1;
          wr_addr          = p_idx_r;
          wr_data          = scan_word;
          rdy_nxt[p_idx_r] = scan_rdy;
          if (scan_take) begin
            best_vld_nxt  = 1'b1;
            best_idx_nxt  = p_idx_r;
            best_prio_nxt = rd_data.prio;
            best_inc_nxt  = scan_inc;
          end
        end
        // issue the next read, or leave once every slot is issued
        if (rd_cnt_r < n_act) begin
          rd_en      = 1'b1;
          rd_addr    = rd_cnt_r[IW-1:0];
          pv_nxt     = 1'b1;
          p_idx_nxt  = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + NW'(1);
        end else begin
          st_nxt = ST_FRD;
        end
      end

      ST_FRD: begin
        // fetch the winner again; its scan write-back has landed
        rd_en   = best_vld_r;
        rd_addr = best_idx_r;
        st_nxt  = ST_FWR;
      end

      ST_FWR: begin
        // hold here until the result register can take the tick
        if (out_free) begin
          time_nxt    = time_inc;
          out_vld_nxt = 1'b1;
          now_nxt     = pps_pkg::VAL_W'(time_inc);
          if (best_vld_r) begin
            wr_en               = 1'b1;
            wr_addr             = best_idx_r;
            wr_data             = fin_word;
            rdy_nxt[best_idx_r] = (fin_rem != '0);
            run_nxt             = pps_pkg::SLOT_W'(best_idx_r);
            if (fin_rem == '0) begin
              occ_nxt[best_idx_r] = 1'b0;
              kind_nxt            = pps_pkg::KIND_DONE;
              tat_nxt             = pps_pkg::VAL_W'(tat_full);
              wtd_nxt             = fin_wait;
            end else begin
              kind_nxt = pps_pkg::KIND_RAN;
              tat_nxt  = '0;
              wtd_nxt  = '0;
            end
          end else begin
            kind_nxt = pps_pkg::KIND_IDLE;
            run_nxt  = '0;
            tat_nxt  = '0;
            wtd_nxt  = '0;
          end
          st_nxt = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      rd_cnt_r   <= '0;
      pv_r       <= 1'b0;
      best_vld_r <= 1'b0;
      time_r     <= '0;
      occ_r      <= '0;
      rdy_r      <= '0;
      cfg_r      <= pps_pkg::ACTIVE_RST;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      pv_r       <= pv_nxt;
      best_vld_r <= best_vld_nxt;
      time_r     <= time_nxt;
      occ_r      <= occ_nxt;
      rdy_r      <= rdy_nxt;
      cfg_r      <= cfg_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    p_idx_r     <= p_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_inc_r  <= best_inc_nxt;
    kind_r      <= kind_nxt;
    run_r       <= run_nxt;
    tat_r       <= tat_nxt;
    wtd_r       <= wtd_nxt;
    now_r       <= now_nxt;
  end

  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.kind       = kind_r;
  assign out_rsp.run_slot   = run_r;
  assign out_rsp.turnaround = tat_r;
  assign out_rsp.waited     = wtd_r;
  assign out_rsp.now        = now_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler: table, starvation run, random phases.

module tb_top;
  import pps_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  // The longest quiet stretch is the receiver hold-off plus the processing of one tick.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 650;
  localparam int STARVE_TICKS = 64;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  arrival;
    logic [VAL_W-1:0]  burst;
    logic [PRIO_W-1:0] prio;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] run_slot;
    logic [VAL_W-1:0]  turnaround;
    logic [VAL_W-1:0]  waited;
    logic [VAL_W-1:0]  now;
  } result_t;

  // One line of the directed table: either a register write or a request,
  // the latter optionally carrying a hand-typed expected result.
  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg_val;
    request_t          req;
    bit                pinned;
    result_t           res;
  } table_row_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  pps_req_if req_if ();
  pps_rsp_if rsp_if ();

  preemptive_priority_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (req_if),
    .out_rsp    (rsp_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler model state: a private copy of the slot table, time and the
  // participation register, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]  sched_arrive [SLOTS_DEF];
  logic [VAL_W-1:0]  sched_burst  [SLOTS_DEF];
  logic [PRIO_W-1:0] sched_prio   [SLOTS_DEF];
  logic [VAL_W-1:0]  sched_left   [SLOTS_DEF];
  logic [VAL_W-1:0]  sched_waited [SLOTS_DEF];
  logic [VAL_W-1:0]  sched_now;
  logic [CFG_W-1:0]  sched_active;

  result_t    pending_results [$];
  table_row_t stim_rows [$];

  int errors;
  int n_loads, n_ticks, n_done, n_idle;
  int settings_used;
  int holds_done;
  int quiet_cycles;

  // Sender controls
  bit      pin_on;
  result_t pin_res;
  int      burst_left;
  bit      gapless;

  // Receiver controls
  bit        hold_ask;
  int        hold_left;
  bit        rx_free;
  rx_style_t rx_style;
  int        rx_phase;
  logic [7:0] rx_mask;

  // Compute the result of one request and advance the model state.
  function automatic result_t schedule_step(request_t r);
    result_t res;
    int      n;
    int      best;
    int      best_p;
    int      i;
    res = '0;
    n = (int'(sched_active) > SLOTS_DEF) ? SLOTS_DEF : int'(sched_active);
    if (r.op == OP_LOAD) begin
      sched_arrive[r.slot] = r.arrival;
      sched_burst[r.slot]  = r.burst;
      sched_prio[r.slot]   = r.prio;
      sched_left[r.slot]   = '0;
      sched_waited[r.slot] = '0;
      res.kind = KIND_LOAD;
    end else begin
      // Arrivals first: a loaded slot whose arrival matches time gets its full burst.
      for (i = 0; i < n; i++) begin
        if (sched_prio[i] != '0 && sched_arrive[i] == sched_now) begin
          sched_left[i] = sched_burst[i];
        end
      end
      // Pick the smallest nonzero priority; strict compare keeps the lowest index on a tie.
      best   = -1;
      best_p = 256;
      for (i = 0; i < n; i++) begin
        if (sched_prio[i] != '0 && sched_left[i] != '0 && int'(sched_prio[i]) < best_p) begin
          best_p = int'(sched_prio[i]);
          best   = i;
        end
      end
      sched_now = sched_now + 1'b1;
      if (best < 0) begin
        res.kind = KIND_IDLE;
      end else begin
        sched_left[best] = sched_left[best] - 1'b1;
        res.run_slot = SLOT_W'(best);
        res.kind     = KIND_RAN;
        if (sched_left[best] == '0) begin
          res.kind       = KIND_DONE;
          res.turnaround = sched_now - sched_arrive[best];
          res.waited     = sched_waited[best];
          sched_prio[best] = '0;
        end
        // Charge one waiting unit to every other ready slot, holding at the cap.
        for (i = 0; i < n; i++) begin
          if (i != best && sched_prio[i] != '0 && sched_left[i] != '0) begin
            if (sched_waited[i] != WAIT_MAX) begin
              sched_waited[i] = sched_waited[i] + 1'b1;
            end
          end
        end
      end
    end
    res.now = sched_now;
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  // ---------------------------------------------------------------------------
  // Observer: at each rising edge, check a delivered result against the oldest
  // expectation first, then predict for a newly accepted request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    result_t  got;
    result_t  want;
    request_t r;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.kind       = rsp_if.kind;
        got.run_slot   = rsp_if.run_slot;
        got.turnaround = rsp_if.turnaround;
        got.waited     = rsp_if.waited;
        got.now        = rsp_if.now;
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no request outstanding, kind", got.kind, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
          if (got.run_slot !== want.run_slot)
            flag_mismatch("run_slot", got.run_slot, want.run_slot);
          if (got.turnaround !== want.turnaround)
            flag_mismatch("turnaround", got.turnaround, want.turnaround);
          if (got.waited !== want.waited) flag_mismatch("waited", got.waited, want.waited);
          if (got.now !== want.now) flag_mismatch("now", got.now, want.now);
        end
        if (got.kind == KIND_DONE) n_done++;
        if (got.kind == KIND_IDLE) n_idle++;
      end
      if (req_if.valid && req_if.ready) begin
        r.op      = req_if.op;
        r.slot    = req_if.slot;
        r.arrival = req_if.arrival;
        r.burst   = req_if.burst;
        r.prio    = req_if.priority_req;
        want = schedule_step(r);
        // Table rows with a hand-typed answer override the model's.
        if (pin_on) want = pin_res;
        pending_results.push_back(want);
        if (r.op == OP_LOAD) n_loads++;
        else n_ticks++;
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls follow a style picked at random for a random stretch.
  // A hold-off request from the main sequence drops ready for HOLD_CYCLES,
  // counted here, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (rx_free) begin
      rsp_if.ready <= 1'b1;
    end else begin
      if (rx_phase == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_mask  = 8'($urandom);
        rx_phase = $urandom_range(20, 120);
      end
      rx_phase--;
      rx_mask = {rx_mask[0], rx_mask[7:1]};
      case (rx_style)
        RX_STEADY:  rsp_if.ready <= 1'b1;
        RX_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: rsp_if.ready <= rx_mask[0];
        default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one request, in bursts with random gaps unless gapless is set;
  // return at the rising edge that accepts it.
  task automatic offer(request_t r, bit pinned, result_t pin);
    int gap;
    gap = 0;
    if (!gapless) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 14);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.op           <= r.op;
    req_if.slot         <= r.slot;
    req_if.arrival      <= r.arrival;
    req_if.burst        <= r.burst;
    req_if.priority_req <= r.prio;
    req_if.valid        <= 1'b1;
    pin_on  = pinned;
    pin_res = pin;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Write active_slots once the block has drained: drop valid, wait for every
  // result, allow a few more cycles, then pulse the write enable.
  task automatic write_active(logic [CFG_W-1:0] v);
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    sched_active = v;
    settings_used++;
  endtask

  task automatic put_cfg(logic [CFG_W-1:0] v);
    table_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    stim_rows.push_back(row);
  endtask

  task automatic put_req(logic [OP_W-1:0] op, int slot, int arrival, int burst, int prio,
                         bit pinned, logic [KIND_W-1:0] kind, int run, int tat, int wtd,
                         int now_v);
    table_row_t row;
    row                = '{default: '0};
    row.req.op         = op;
    row.req.slot       = SLOT_W'(slot);
    row.req.arrival    = VAL_W'(arrival);
    row.req.burst      = VAL_W'(burst);
    row.req.prio       = PRIO_W'(prio);
    row.pinned         = pinned;
    row.res.kind       = kind;
    row.res.run_slot   = SLOT_W'(run);
    row.res.turnaround = VAL_W'(tat);
    row.res.waited     = VAL_W'(wtd);
    row.res.now        = VAL_W'(now_v);
    stim_rows.push_back(row);
  endtask

  // Random request: mostly arrivals a few ticks ahead of time so tasks really
  // arrive, short bursts and a narrow priority band for ties and preemption,
  // with some full-range fields, zero bursts and zero priorities mixed in.
  function automatic request_t make_random_request();
    request_t r;
    int       pick;
    r.op   = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_TICK;
    r.slot = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
    pick = $urandom_range(0, 99);
    if (pick < 80) r.arrival = sched_now + VAL_W'($urandom_range(0, 15));
    else r.arrival = VAL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 85) r.burst = VAL_W'($urandom_range(1, 8));
    else if (pick < 95) r.burst = VAL_W'($urandom_range(1, 65535));
    else r.burst = '0;
    pick = $urandom_range(0, 99);
    if (pick < 50) r.prio = PRIO_W'($urandom_range(1, 4));
    else if (pick < 95) r.prio = PRIO_W'($urandom_range(1, 255));
    else r.prio = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    result_t          none;
    request_t         r;
    logic [VAL_W-1:0] t0;
    logic [CFG_W-1:0] phase_setting [8];
    int               per_phase;
    int               k;

    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_if.valid = 1'b0;
    req_if.op    = OP_LOAD;
    req_if.slot  = '0;
    req_if.arrival      = '0;
    req_if.burst        = '0;
    req_if.priority_req = '0;
    rsp_if.ready = 1'b0;
    none         = '0;

    for (k = 0; k < SLOTS_DEF; k++) begin
      sched_arrive[k] = '0;
      sched_burst[k]  = '0;
      sched_prio[k]   = '0;
      sched_left[k]   = '0;
      sched_waited[k] = '0;
    end
    sched_now    = '0;
    sched_active = ACTIVE_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Time starts at zero with all eight slots taking part.
    // Tick straight out of reset: nothing loaded, idle, time still moves.
    put_req(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 0, 0, 0, 1);
    // All-ones load and all-minimum load; slot 7 arrives in the past.
    put_req(OP_LOAD, 0, 'hFFFF, 'hFFFF, 'hFF, 1, KIND_LOAD, 0, 0, 0, 1);
    put_req(OP_LOAD, 7, 0, 1, 1, 1, KIND_LOAD, 0, 0, 0, 1);
    // Two equal priorities arriving together: lower index goes first.
    put_req(OP_LOAD, 3, 2, 2, 5, 1, KIND_LOAD, 0, 0, 0, 1);
    put_req(OP_LOAD, 4, 2, 1, 5, 1, KIND_LOAD, 0, 0, 0, 1);
    // Zero burst never becomes ready; zero priority is an empty slot.
    put_req(OP_LOAD, 5, 3, 0, 9, 1, KIND_LOAD, 0, 0, 0, 1);
    put_req(OP_LOAD, 6, 3, 4, 0, 1, KIND_LOAD, 0, 0, 0, 1);
    put_req(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 0, 0, 0, 2);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    // A high-priority arrival preempts a running task.
    put_req(OP_LOAD, 1, 6, 3, 10, 0, KIND_LOAD, 0, 0, 0, 0);
    put_req(OP_LOAD, 2, 7, 1, 3, 0, KIND_LOAD, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 0, KIND_RAN, 0, 0, 0, 0);
    // No slot takes part: the tick is idle although slot 3 arrives.
    put_cfg(4'd0);
    put_req(OP_LOAD, 3, 10, 2, 1, 0, KIND_LOAD, 0, 0, 0, 0);
    put_req(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 0, 0, 0, 11);
    // Register above the slot count behaves as all eight slots.
    put_cfg(4'd15);
    put_req(OP_LOAD, 3, 11, 1, 1, 1, KIND_LOAD, 0, 0, 0, 11);
    put_req(OP_TICK, 0, 0, 0, 0, 1, KIND_DONE, 3, 1, 0, 12);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_active(stim_rows[i].cfg_val);
      else offer(stim_rows[i].req, stim_rows[i].pinned, stim_rows[i].res);
    end

    // Starvation run: three slots, full speed. A low-priority task runs once,
    // a longer burst then holds it off, a top-priority arrival preempts that
    // burst, and the starved task finishes last with the largest waiting count.
    write_active(4'd3);
    rx_free = 1'b1;
    gapless = 1'b1;
    t0 = sched_now;
    r  = '0;
    r.op = OP_LOAD;
    r.slot = 3'd1; r.arrival = t0;              r.burst = 16'd3;   r.prio = 8'd200;
    offer(r, 1'b0, none);
    r.slot = 3'd0; r.arrival = t0 + 16'd1;      r.burst = 16'd20;  r.prio = 8'd2;
    offer(r, 1'b0, none);
    r.slot = 3'd2; r.arrival = t0 + 16'd2;      r.burst = 16'd4;   r.prio = 8'd1;
    offer(r, 1'b0, none);
    r = '0;
    r.op = OP_TICK;
    k = 0;
    while ((sched_prio[0] != '0 || sched_prio[1] != '0 || sched_prio[2] != '0)
           && k < STARVE_TICKS) begin
      offer(r, 1'b0, none);
      k++;
    end
    rx_free = 1'b0;
    gapless = 1'b0;

    // Random phases over a spread of register values, extremes included.
    phase_setting[0] = 4'd1;
    phase_setting[1] = 4'd8;
    phase_setting[2] = 4'd15;
    phase_setting[3] = 4'd0;
    phase_setting[4] = 4'd5;
    phase_setting[5] = 4'd2;
    phase_setting[6] = CFG_W'($urandom_range(1, 15));
    phase_setting[7] = 4'd8;
    per_phase = RANDOM_ITEMS / 8;
    for (int p = 0; p < 8; p++) begin
      write_active(phase_setting[p]);
      // First full-width phase: hold the receiver off and keep offering.
      if (p == 1) begin
        hold_ask = 1'b1;
        gapless  = 1'b1;
      end
      for (k = 0; k < per_phase; k++) begin
        if (k == 12) gapless = 1'b0;
        offer(make_random_request(), 1'b0, none);
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d requests (%0d loads, %0d ticks) over %0d register writes;",
             n_loads + n_ticks, n_loads, n_ticks, settings_used);
    $display("%0d tasks finished, %0d idle ticks, %0d receiver hold-offs.",
             n_done, n_idle, holds_done);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
